>>> rtl/rgbnv_pkg.sv
package rgbnv_pkg;

	// frame counters and size registers
	localparam int DIM_BITS = 16;
	localparam int OFFSET_W = 32;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// signed products of 8-bit components with BT.601 weights fit in 18 bits
	localparam int COEF_W = 18;

	localparam logic signed [COEF_W-1:0] Y_R  = 18'sd66;
	localparam logic signed [COEF_W-1:0] Y_G  = 18'sd129;
	localparam logic signed [COEF_W-1:0] Y_B  = 18'sd25;
	localparam logic signed [COEF_W-1:0] CB_R = -18'sd38;
	localparam logic signed [COEF_W-1:0] CB_G = -18'sd74;
	localparam logic signed [COEF_W-1:0] CB_B = 18'sd112;
	localparam logic signed [COEF_W-1:0] CR_R = 18'sd112;
	localparam logic signed [COEF_W-1:0] CR_G = -18'sd94;
	localparam logic signed [COEF_W-1:0] CR_B = -18'sd18;
	localparam logic signed [COEF_W-1:0] ROUND_TERM = 18'sd128;

	localparam logic [7:0] LUMA_BIAS   = 8'd16;
	localparam logic [7:0] CHROMA_BIAS = 8'd128;

	// per-pixel control and position carried from the input stage
	typedef struct packed {
		logic                chroma_valid;
		logic                row_end;
		logic                frame_end;
		logic [OFFSET_W-1:0] luma_offset;
		logic [OFFSET_W-1:0] chroma_offset;
	} pix_ctl_t;

endpackage

>>> rtl/rgb_to_nv12_converter_top.sv
// Streaming RGB to NV12 converter (BT.601 studio range). One 24-bit RGB pixel per beat in
// raster order; every pixel gives one output beat with its Y value and Y-plane byte offset,
// and pixels on even rows at even columns that have a right neighbour also carry Cb/Cr taken
// from that pixel alone (no averaging) with the UV-plane offset of Cb (Cr sits at +1).
// tlast marks the last pixel of a row, tuser[1] the last pixel of the frame, after which
// the counters restart at the top-left pixel. Throughput is one pixel per clock unless
// m_axis_tready stalls. An input stage registers the pixel and row/column bookkeeping,
// an output register holds the constant-multiply math. The user must write frame size
// registers via cfg port only while no pixel is in flight (unenforced); 0 counts as 1.
module rgb_to_nv12_converter_top
	import rgbnv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [23:0]            s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]

	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// luma[7:0], luma_offset[39:8], blue_diff[47:40], red_diff[55:48], chroma_offset[87:56]
	output logic [87:0]            m_axis_tdata,
	output logic                   m_axis_tlast,   // row_end
	output logic [1:0]             m_axis_tuser    // chroma_valid[0], frame_end[1]
);

	logic [DIM_BITS-1:0] width_q, height_q;
	logic [DIM_BITS-1:0] col_q, row_q;
	logic [OFFSET_W-1:0] lpos_q, cbase_q;

	logic                valid_s1;
	logic [7:0]          red_s1, green_s1, blue_s1;
	pix_ctl_t            ctl_s1;

	logic                valid_s2;
	logic [7:0]          luma_s2, cb_s2, cr_s2;
	pix_ctl_t            ctl_s2;

	logic                in_beat, adv_s2;
	logic [DIM_BITS-1:0] w_eff, h_eff;
	logic                last_col, last_row, cvalid;
	logic [DIM_BITS:0]   col_next;
	pix_ctl_t            ctl_in;

	logic signed [COEF_W-1:0] r_x, g_x, b_x;
	logic signed [COEF_W-1:0] y_sum, cb_sum, cr_sum;
	logic signed [COEF_W-1:0] y_sh, cb_sh, cr_sh;
	logic [7:0]               luma_c, cb_c, cr_c;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(1);
			height_q <= DIM_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[DIM_BITS-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// ---------------------------------------------------------------- position bookkeeping
	always_comb begin
		w_eff    = (width_q == '0) ? DIM_BITS'(1) : width_q;
		h_eff    = (height_q == '0) ? DIM_BITS'(1) : height_q;
		last_col = col_q >= (w_eff - DIM_BITS'(1));
		last_row = row_q >= (h_eff - DIM_BITS'(1));
		col_next = {1'b0, col_q} + (DIM_BITS+1)'(1);
		cvalid   = !row_q[0] && !col_q[0] && (col_next < {1'b0, w_eff});

		ctl_in.chroma_valid  = cvalid;
		ctl_in.row_end       = last_col;
		ctl_in.frame_end     = last_col && last_row;
		ctl_in.luma_offset   = lpos_q;
		ctl_in.chroma_offset = cvalid ? (cbase_q + OFFSET_W'(col_q)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			lpos_q  <= '0;
			cbase_q <= '0;
		end else if (in_beat) begin
			if (last_col && last_row) begin
				col_q   <= '0;
				row_q   <= '0;
				lpos_q  <= '0;
				cbase_q <= '0;
			end else if (last_col) begin
				// chroma rows advance once per pair of luma rows
				if (row_q[0])
					cbase_q <= cbase_q + OFFSET_W'(w_eff);
				col_q  <= '0;
				row_q  <= row_q + DIM_BITS'(1);
				lpos_q <= lpos_q + OFFSET_W'(1);
			end else begin
				col_q  <= col_next[DIM_BITS-1:0];
				lpos_q <= lpos_q + OFFSET_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			red_s1   <= s_axis_tdata[7:0];
			green_s1 <= s_axis_tdata[15:8];
			blue_s1  <= s_axis_tdata[23:16];
			ctl_s1   <= ctl_in;
		end
	end

	// ---------------------------------------------------------------- color math
	always_comb begin
		r_x = $signed({{(COEF_W-8){1'b0}}, red_s1});
		g_x = $signed({{(COEF_W-8){1'b0}}, green_s1});
		b_x = $signed({{(COEF_W-8){1'b0}}, blue_s1});

		y_sum  = Y_R * r_x + Y_G * g_x + Y_B * b_x + ROUND_TERM;
		cb_sum = CB_R * r_x + CB_G * g_x + CB_B * b_x + ROUND_TERM;
		cr_sum = CR_R * r_x + CR_G * g_x + CR_B * b_x + ROUND_TERM;

		// flooring shift, then bias modulo 256
		y_sh  = y_sum >>> 8;
		cb_sh = cb_sum >>> 8;
		cr_sh = cr_sum >>> 8;

		luma_c = y_sh[7:0] + LUMA_BIAS;
		cb_c   = ctl_s1.chroma_valid ? (cb_sh[7:0] + CHROMA_BIAS) : 8'd0;
		cr_c   = ctl_s1.chroma_valid ? (cr_sh[7:0] + CHROMA_BIAS) : 8'd0;
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			luma_s2 <= luma_c;
			cb_s2   <= cb_c;
			cr_s2   <= cr_c;
			ctl_s2  <= ctl_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {ctl_s2.chroma_offset, cr_s2, cb_s2, ctl_s2.luma_offset, luma_s2};
	assign m_axis_tlast  = ctl_s2.row_end;
	assign m_axis_tuser  = {ctl_s2.frame_end, ctl_s2.chroma_valid};

endmodule
